/* rtl/gpiolk_pkg.sv */
// shared types, register codes and helpers for the gpio port with configuration lock
`default_nettype none
package gpiolk_pkg;

  localparam int PIN_COUNT = 16;
  localparam logic [15:0] PIN_MASK = 16'((32'd1 << PIN_COUNT) - 32'd1);
  localparam logic [31:0] CFG_RESET = 32'h4444_4444;

  // register selector codes
  localparam logic [2:0] SEL_CRL  = 3'd0;
  localparam logic [2:0] SEL_CRH  = 3'd1;
  localparam logic [2:0] SEL_IDR  = 3'd2;
  localparam logic [2:0] SEL_ODR  = 3'd3;
  localparam logic [2:0] SEL_BSRR = 3'd4;
  localparam logic [2:0] SEL_BRR  = 3'd5;
  localparam logic [2:0] SEL_LCKR = 3'd6;

  localparam logic MODE_WRITE = 1'b1;

  typedef struct packed {
    logic        wr;
    logic        lckk;
    logic [15:0] lck;
  } lock_req_t;

  typedef struct packed {
    logic        key;
    logic        key_next;
    logic [15:0] bits;
  } lock_status_t;

  // nibble mask of those of the eight pins that the lock holds
  function automatic logic [31:0] frozen_nibbles(logic key, logic [7:0] lk8);
    logic [31:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      if (key && lk8[i]) begin
        m[4*i +: 4] = 4'hf;
      end
    end
    return m;
  endfunction

endpackage
`default_nettype wire

/* rtl/gpiolk_lock.sv */
// lock register and lock key sequence
`default_nettype none
module gpiolk_lock (
  input  wire                       clk,
  input  wire                       rst,
  input  gpiolk_pkg::lock_req_t     req,
  output gpiolk_pkg::lock_status_t  status
);

  localparam logic [1:0] STEP_IDLE = 2'd0;
  localparam logic [1:0] STEP_ONE  = 2'd1;
  localparam logic [1:0] STEP_TWO  = 2'd2;

  logic [1:0]  lock_step;
  logic [1:0]  lock_step_next;
  logic        lock_key;
  logic        lock_key_next;
  logic [15:0] lock_bits;
  logic [15:0] lock_bits_next;
  logic        same;

  always_comb begin
    lock_step_next = lock_step;
    lock_key_next  = lock_key;
    lock_bits_next = lock_bits;
    same = ((req.lck & gpiolk_pkg::PIN_MASK) == lock_bits);
    if (req.wr && !lock_key) begin
      lock_bits_next = req.lck & gpiolk_pkg::PIN_MASK;
      case (lock_step)
        STEP_ONE: begin
          lock_step_next = (!req.lckk && same) ? STEP_TWO
                         : (req.lckk ? STEP_ONE : STEP_IDLE);
        end
        STEP_TWO: begin
          if (req.lckk && same) begin
            lock_key_next  = 1'b1;
            lock_step_next = STEP_IDLE;
          end else begin
            lock_step_next = req.lckk ? STEP_ONE : STEP_IDLE;
          end
        end
        default: begin
          // idle and the unused code restart on lckk=1
          lock_step_next = req.lckk ? STEP_ONE : STEP_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lock_step <= STEP_IDLE;
      lock_key  <= 1'b0;
      lock_bits <= '0;
    end else begin
      lock_step <= lock_step_next;
      lock_key  <= lock_key_next;
      lock_bits <= lock_bits_next;
    end
  end

  assign status.key      = lock_key;
  assign status.key_next = lock_key_next;
  assign status.bits     = lock_bits;

endmodule
`default_nettype wire

/* rtl/gpio_port_with_config_lock_top.sv */
// top level of the 16-pin gpio port with configuration lock
//
//  channel | group  | tdata                                 | tuser
//  --------+--------+---------------------------------------+----------------------
//  access  | s_axis | write_data[31:0] pin_levels[47:32]    | mode[0] reg_select[3:1]
//  result  | m_axis | read_data[31:0] pin_drive[47:32]      | -
//          |        | lock_active[48], zero pad [55:49]     |
//
// one access per cycle when unstalled; its result is on m_axis in the next cycle.
// all state is updated in the same cycle the access is taken, so accesses issue
// back to back. the result register frees s_axis_tready whenever it is empty or
// being drained; a stalled result holds the next access off.
// synchronous reset restores the port registers and empties the result register.
`default_nettype none
module gpio_port_with_config_lock_top (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [47:0] s_axis_tdata,   // write_data[31:0], pin_levels[47:32]
  input  wire  [3:0]  s_axis_tuser,   // mode[0], reg_select[3:1]
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [55:0] m_axis_tdata    // read_data[31:0], pin_drive[47:32], lock_active[48]
);

  logic        accept;
  logic        wr;
  logic [2:0]  sel;
  logic [31:0] data;
  logic [15:0] levels;

  logic [31:0] config_low;
  logic [31:0] config_high;
  logic [15:0] output_latch;
  logic [31:0] config_low_next;
  logic [31:0] config_high_next;
  logic [15:0] output_latch_next;
  logic [31:0] keep_low;
  logic [31:0] keep_high;
  logic [31:0] rd;

  logic        out_valid;
  logic [31:0] out_read_data;
  logic [15:0] out_pin_drive;
  logic        out_lock;

  gpiolk_pkg::lock_req_t    lock_req;
  gpiolk_pkg::lock_status_t lock_status;

  assign s_axis_tready = !out_valid || m_axis_tready;
  assign accept = s_axis_tvalid && s_axis_tready;
  assign wr     = (s_axis_tuser[0] == gpiolk_pkg::MODE_WRITE);
  assign sel    = s_axis_tuser[3:1];
  assign data   = s_axis_tdata[31:0];
  assign levels = s_axis_tdata[47:32] & gpiolk_pkg::PIN_MASK;

  assign lock_req.wr   = accept && wr && (sel == gpiolk_pkg::SEL_LCKR);
  assign lock_req.lckk = data[16];
  assign lock_req.lck  = data[15:0];

  gpiolk_lock u_lock (
    .clk    (clk),
    .rst    (rst),
    .req    (lock_req),
    .status (lock_status)
  );

  assign keep_low  = gpiolk_pkg::frozen_nibbles(lock_status.key, lock_status.bits[7:0]);
  assign keep_high = gpiolk_pkg::frozen_nibbles(lock_status.key, lock_status.bits[15:8]);

  always_comb begin
    config_low_next   = config_low;
    config_high_next  = config_high;
    output_latch_next = output_latch;
    rd = '0;
    if (wr) begin
      case (sel)
        gpiolk_pkg::SEL_CRL:  config_low_next = (config_low & keep_low) | (data & ~keep_low);
        gpiolk_pkg::SEL_CRH:  config_high_next = (config_high & keep_high)
                                               | (data & ~keep_high);
        gpiolk_pkg::SEL_ODR:  output_latch_next = data[15:0] & gpiolk_pkg::PIN_MASK;
        // set wins over reset
        gpiolk_pkg::SEL_BSRR: output_latch_next = ((output_latch & ~data[31:16]) | data[15:0])
                                                & gpiolk_pkg::PIN_MASK;
        gpiolk_pkg::SEL_BRR:  output_latch_next = output_latch & ~data[15:0]
                                                & gpiolk_pkg::PIN_MASK;
        default: ;
      endcase
    end else begin
      case (sel)
        gpiolk_pkg::SEL_CRL:  rd = config_low;
        gpiolk_pkg::SEL_CRH:  rd = config_high;
        gpiolk_pkg::SEL_IDR:  rd = {16'd0, levels};
        gpiolk_pkg::SEL_ODR:  rd = {16'd0, output_latch};
        gpiolk_pkg::SEL_LCKR: rd = {15'd0, lock_status.key, lock_status.bits};
        default:              rd = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      config_low   <= gpiolk_pkg::CFG_RESET;
      config_high  <= gpiolk_pkg::CFG_RESET;
      output_latch <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (accept) begin
        config_low   <= config_low_next;
        config_high  <= config_high_next;
        output_latch <= output_latch_next;
        out_valid    <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_read_data <= rd;
      out_pin_drive <= output_latch_next;
      out_lock      <= lock_status.key_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'd0, out_lock, out_pin_drive, out_read_data};

endmodule
`default_nettype wire

/* rtl/gpiolk_checker.sv */
// port-level checks for the gpio port, bound to the top level
`default_nettype none
module gpiolk_checker (
  input wire        clk,
  input wire        rst,
  input wire        s_axis_tvalid,
  input wire        s_axis_tready,
  input wire [47:0] s_axis_tdata,
  input wire [3:0]  s_axis_tuser,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready,
  input wire [55:0] m_axis_tdata
);

  logic acc;
  logic acc_wr;
  assign acc    = s_axis_tvalid && s_axis_tready;
  assign acc_wr = acc && (s_axis_tuser[0] == gpiolk_pkg::MODE_WRITE);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("access refused with empty result register");

  a_write_reads_zero: assert property (@(posedge clk) disable iff (rst)
    acc_wr |=> m_axis_tvalid && (m_axis_tdata[31:0] == 32'd0))
    else $error("write transfer returned nonzero read data");

  a_odr_drive: assert property (@(posedge clk) disable iff (rst)
    acc_wr && (s_axis_tuser[3:1] == gpiolk_pkg::SEL_ODR)
    |=> m_axis_tdata[47:32] == ($past(s_axis_tdata[15:0]) & gpiolk_pkg::PIN_MASK))
    else $error("odr write not driven on the pins");

endmodule

bind gpio_port_with_config_lock_top gpiolk_checker u_gpiolk_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
